/* sv/bwt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and sizes for the band-limited wavetable reader.
// Depends on nothing; bwt_band_table, bwt_lerp, the top level and the testbench refer to it by scoped names.
package bwt_pkg;

	localparam int NUM_BANDS        = 16;
	localparam int MAX_BAND_SAMPLES = 2048;
	localparam int SAMPLE_BITS      = 16;

	localparam int BAND_W  = $clog2(NUM_BANDS);
	localparam int SIDX_W  = $clog2(MAX_BAND_SAMPLES);
	localparam int LEN_W   = SIDX_W + 1;
	localparam int ADDR_W  = BAND_W + SIDX_W;
	localparam int DEPTH   = NUM_BANDS * MAX_BAND_SAMPLES;
	localparam int FREQ_W  = 24;
	localparam int PHASE_W = 16;
	localparam int TCNT_W  = 5;
	localparam int POS_W   = PHASE_W + LEN_W;
	localparam int CFG_W   = 24;

	typedef enum logic [1:0] {
		OP_QUERY       = 2'd0,
		OP_LOAD_DESC   = 2'd1,
		OP_LOAD_SAMPLE = 2'd2,
		OP_NONE        = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		CFG_LOWEST_FREQ = 1'b0,
		CFG_TABLE_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         band_select;
		logic [10:0]        sample_index;
		logic signed [15:0] sample_value;
		logic [23:0]        upper_bound;
		logic [11:0]        band_length;
		logic [23:0]        frequency;
		logic [15:0]        phase;
	} cmd_word_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               silent;
		logic [3:0]         band_used;
	} res_word_t;

	// one descriptor write, upper bound or length
	typedef struct packed {
		logic              en;
		logic [BAND_W-1:0] band;
		logic [FREQ_W-1:0] upper;
		logic [LEN_W-1:0]  size;
	} band_wr_t;

	// per-result control that rides along the interpolator
	typedef struct packed {
		logic              silent;
		logic [BAND_W-1:0] band;
	} lerp_ctl_t;

endpackage

/* sv/bwt_ram.sv */
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing.
module bwt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

/* sv/bwt_band_table.sv */
`timescale 1ns / 1ps
// Band descriptor registers: upper bounds, lengths, bound compare and band pick.
// Depends on bwt_pkg.
module bwt_band_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bwt_pkg::band_wr_t                  upper_wr,
	input  bwt_pkg::band_wr_t                  size_wr,
	input  logic [bwt_pkg::FREQ_W-1:0]         freq,
	input  logic [bwt_pkg::BAND_W-1:0]         count_m1,
	output logic [bwt_pkg::NUM_BANDS-1:0]      hit,
	input  logic [bwt_pkg::NUM_BANDS-1:0]      pick_hit,
	input  logic [bwt_pkg::BAND_W-1:0]         pick_count_m1,
	output logic [bwt_pkg::BAND_W-1:0]         pick_band,
	output logic [bwt_pkg::LEN_W-1:0]          pick_size
);

	logic [bwt_pkg::FREQ_W-1:0] upper_q [bwt_pkg::NUM_BANDS];
	logic [bwt_pkg::LEN_W-1:0]  size_q  [bwt_pkg::NUM_BANDS];
	logic [bwt_pkg::LEN_W-1:0]  raw_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bwt_pkg::NUM_BANDS; i++) begin
				upper_q[i] <= '0;
				size_q[i]  <= '0;
			end
		end else begin
			if (upper_wr.en) begin
				upper_q[upper_wr.band] <= upper_wr.upper;
			end
			if (size_wr.en) begin
				// saturate to the band capacity
				if (size_wr.size > bwt_pkg::LEN_W'(bwt_pkg::MAX_BAND_SAMPLES)) begin
					size_q[size_wr.band] <= bwt_pkg::LEN_W'(bwt_pkg::MAX_BAND_SAMPLES);
				end else begin
					size_q[size_wr.band] <= size_wr.size;
				end
			end
		end
	end

	// bands past the searched count never hit
	always_comb begin
		for (int i = 0; i < bwt_pkg::NUM_BANDS; i++) begin
			hit[i] = (bwt_pkg::BAND_W'(i) <= count_m1) && (upper_q[i] >= freq);
		end
	end

	// first hit wins; no hit falls back to the last searched band
	always_comb begin
		pick_band = pick_count_m1;
		for (int i = bwt_pkg::NUM_BANDS - 1; i >= 0; i--) begin
			if (pick_hit[i]) begin
				pick_band = bwt_pkg::BAND_W'(i);
			end
		end
		raw_size  = size_q[pick_band];
		pick_size = (raw_size == '0) ? bwt_pkg::LEN_W'(1) : raw_size;
	end

endmodule

/* sv/bwt_lerp.sv */
`timescale 1ns / 1ps
// Interpolator tail: difference times fraction, then floor shift and add.
// Depends on bwt_pkg.
module bwt_lerp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   up_valid,
	output logic                                   up_take,
	input  bwt_pkg::lerp_ctl_t                     up_ctl,
	input  logic signed [bwt_pkg::SAMPLE_BITS-1:0] samp_a,
	input  logic signed [bwt_pkg::SAMPLE_BITS-1:0] samp_b,
	input  logic [bwt_pkg::PHASE_W-1:0]            frac,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output bwt_pkg::res_word_t                     res,
	output logic                                   mul_valid
);

	localparam int SB    = bwt_pkg::SAMPLE_BITS;
	localparam int PW    = bwt_pkg::PHASE_W;
	localparam int PROD_W = SB + PW + 2;

	logic                     valid_s5;
	bwt_pkg::lerp_ctl_t       ctl_s5;
	logic signed [SB-1:0]     a_s5;
	logic signed [PROD_W-1:0] prod_s5;
	logic                     en_s5;
	logic                     en_o;
	logic signed [SB:0]       diff_c;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] sum_c;

	assign en_o    = !res_valid || !res_stall;
	assign en_s5   = !valid_s5 || en_o;
	assign up_take = en_s5;
	assign mul_valid = valid_s5;

	assign diff_c = {samp_b[SB-1], samp_b} - {samp_a[SB-1], samp_a};
	assign prod_c = diff_c * $signed({1'b0, frac});
	// arithmetic shift gives the floor for negative products
	assign sum_c  = PROD_W'(a_s5) + (prod_s5 >>> PW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (en_s5) begin
				valid_s5 <= up_valid;
			end
			if (en_o) begin
				res_valid <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			ctl_s5  <= up_ctl;
			a_s5    <= samp_a;
			prod_s5 <= prod_c;
		end
		if (en_o) begin
			if (ctl_s5.silent) begin
				res.sample_out <= '0;
				res.band_used  <= '0;
			end else begin
				res.sample_out <= sum_c[SB-1:0];
				res.band_used  <= ctl_s5.band;
			end
			res.silent <= ctl_s5.silent;
		end
	end

endmodule

/* sv/band_limited_wavetable_lookup.sv */
`timescale 1ns / 1ps
// Top level of the band-limited wavetable reader: command pipeline and storage.
// Depends on bwt_pkg, bwt_ram, bwt_band_table and bwt_lerp.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one word per cycle while
//   cmd_stall is low: a query (frequency, phase), a band descriptor load or a
//   single sample load. Op code three is dropped on entry. Loads give no result word.
//   res channel (res_valid / res_stall / res) carries one word per query: the
//   interpolated sample, the silent flag and the band that was used.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   lowest_frequency and table_count; it is always ready. Write it only while
//   no query is in flight.
//   Queries pass through six register stages (bound compare, band pick, phase
//   multiply, sample read, difference multiply, output) and a sample RAM with
//   two read ports; the block takes one word per cycle when nothing stalls.
//   Loads take effect in order with queries: each kind of storage is written
//   at the same stage at which queries read it.
//   Reset clears the descriptors, lowest_frequency and all valid bits at once and
//   sets table_count to one; sample memory is not cleared and holds garbage until loaded.
//   A stall on res holds the output word; the stages behind it fill their
//   bubbles first, and cmd_stall rises only when every stage is occupied.
module band_limited_wavetable_lookup (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  bwt_pkg::cmd_word_t         cmd,
	output logic                       res_valid,
	input  logic                       res_stall,
	output bwt_pkg::res_word_t         res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [0:0]                 cfg_index,
	input  logic [bwt_pkg::CFG_W-1:0]  cfg_data
);

	localparam int NB = bwt_pkg::NUM_BANDS;
	localparam int BW = bwt_pkg::BAND_W;
	localparam int SW = bwt_pkg::SIDX_W;
	localparam int LW = bwt_pkg::LEN_W;
	localparam int SB = bwt_pkg::SAMPLE_BITS;
	localparam int PW = bwt_pkg::PHASE_W;

	// configuration registers
	logic [bwt_pkg::FREQ_W-1:0] lowest_freq_q;
	logic [bwt_pkg::TCNT_W-1:0] table_count_q;

	// stage valid bits and enables
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic take_s5;
	logic mul_valid;
	logic accept;

	// stage 1: bound compare done
	logic [1:0]                 op_s1;
	logic [BW-1:0]              band_s1;
	logic [SW-1:0]              sidx_s1;
	logic signed [SB-1:0]       value_s1;
	logic [11:0]                blen_s1;
	logic [PW-1:0]              phase_s1;
	logic                       silent_s1;
	logic [NB-1:0]              hit_s1;
	logic [BW-1:0]              cnt_m1_s1;
	logic                       sidx_ok_s1;

	// stage 2: band picked
	logic [1:0]                 op_s2;
	logic [BW-1:0]              band_s2;
	logic [SW-1:0]              sidx_s2;
	logic signed [SB-1:0]       value_s2;
	logic [PW-1:0]              phase_s2;
	logic                       silent_s2;
	logic [BW-1:0]              sel_s2;
	logic [LW-1:0]              len_s2;
	logic [BW-1:0]              cnt_m1_s2;
	logic                       sidx_ok_s2;

	// stage 3: position known
	logic [1:0]                 op_s3;
	logic [BW-1:0]              band_s3;
	logic [SW-1:0]              sidx_s3;
	logic signed [SB-1:0]       value_s3;
	logic                       silent_s3;
	logic [BW-1:0]              sel_s3;
	logic [LW-1:0]              len_s3;
	logic [LW-1:0]              idx_s3;
	logic [PW-1:0]              frac_s3;
	logic                       sidx_ok_s3;

	// stage 4: samples read (data lives in the RAM output registers)
	bwt_pkg::lerp_ctl_t         ctl_s4;
	logic [PW-1:0]              frac_s4;
	logic [SB-1:0]              ram_a, ram_b;

	// combinational helpers
	logic [BW-1:0]              cnt_m1_c;
	logic [NB-1:0]              hit_c;
	logic [BW-1:0]              pick_band_c;
	logic [LW-1:0]              pick_size_c;
	logic [bwt_pkg::POS_W-1:0]  pos_c;
	logic [LW-1:0]              idx_c;
	logic [LW-1:0]              nxt_c;
	logic [LW-1:0]              inc_c;
	logic                       ram_we;
	bwt_pkg::band_wr_t          upper_wr;
	bwt_pkg::band_wr_t          size_wr;
	bwt_pkg::lerp_ctl_t         ctl_c;

	// pipeline enables: a stage moves when empty or when the next one moves
	assign en_s4     = !valid_s4 || take_s5;
	assign en_s3     = !valid_s3 || en_s4;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign cmd_stall = !en_s1;
	assign accept    = cmd_valid && en_s1;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_freq_q <= '0;
			table_count_q <= bwt_pkg::TCNT_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				bwt_pkg::CFG_LOWEST_FREQ: lowest_freq_q <= cfg_data;
				bwt_pkg::CFG_TABLE_COUNT: table_count_q <= cfg_data[bwt_pkg::TCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the searched band count to one..NUM_BANDS, kept as count minus one
	always_comb begin
		if (table_count_q == '0) begin
			cnt_m1_c = '0;
		end else if (table_count_q >= bwt_pkg::TCNT_W'(NB)) begin
			cnt_m1_c = BW'(NB - 1);
		end else begin
			cnt_m1_c = BW'(table_count_q - bwt_pkg::TCNT_W'(1));
		end
	end

	// upper bounds are written on entry, where queries compare against them
	always_comb begin
		upper_wr       = '0;
		upper_wr.en    = accept && (cmd.op == bwt_pkg::OP_LOAD_DESC) &&
			({1'b0, cmd.band_select} < 5'(NB));
		upper_wr.band  = BW'(cmd.band_select);
		upper_wr.upper = cmd.upper_bound;
	end

	// lengths are written leaving stage 1, where queries pick their length
	always_comb begin
		size_wr      = '0;
		size_wr.en   = valid_s1 && en_s2 && (op_s1 == bwt_pkg::OP_LOAD_DESC) &&
			({1'b0, band_s1} < 5'(NB));
		size_wr.band = band_s1;
		size_wr.size = LW'(blen_s1);
	end

	bwt_band_table u_band_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.upper_wr      (upper_wr),
		.size_wr       (size_wr),
		.freq          (cmd.frequency),
		.count_m1      (cnt_m1_c),
		.hit           (hit_c),
		.pick_hit      (hit_s1),
		.pick_count_m1 (cnt_m1_s1),
		.pick_band     (pick_band_c),
		.pick_size     (pick_size_c)
	);

	// stage valid bits; op three is dropped here, loads leave after the RAM write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= cmd_valid && (cmd.op != bwt_pkg::OP_NONE);
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3 && (op_s3 == bwt_pkg::OP_QUERY);
			end
		end
	end

	// stage 1: compare every bound against the frequency
	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1      <= cmd.op;
			band_s1    <= BW'(cmd.band_select);
			sidx_s1    <= SW'(cmd.sample_index);
			sidx_ok_s1 <= ({1'b0, cmd.sample_index} < 12'(bwt_pkg::MAX_BAND_SAMPLES));
			value_s1   <= SB'(cmd.sample_value);
			blen_s1    <= cmd.band_length;
			phase_s1   <= cmd.phase;
			silent_s1  <= cmd.frequency < lowest_freq_q;
			hit_s1     <= hit_c;
			cnt_m1_s1  <= cnt_m1_c;
		end
	end

	// stage 2: pick the first band that covers the frequency and its length
	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2      <= op_s1;
			band_s2    <= band_s1;
			sidx_s2    <= sidx_s1;
			sidx_ok_s2 <= sidx_ok_s1;
			value_s2   <= value_s1;
			phase_s2   <= phase_s1;
			silent_s2  <= silent_s1;
			sel_s2     <= pick_band_c;
			len_s2     <= pick_size_c;
			cnt_m1_s2  <= cnt_m1_s1;
		end
	end

	// stage 3: position = phase * length, split into index and fraction
	assign pos_c = bwt_pkg::POS_W'(phase_s2) * bwt_pkg::POS_W'(len_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3      <= op_s2;
			band_s3    <= band_s2;
			sidx_s3    <= sidx_s2;
			sidx_ok_s3 <= sidx_ok_s2;
			value_s3   <= value_s2;
			silent_s3  <= silent_s2;
			sel_s3     <= sel_s2;
			len_s3     <= len_s2;
			idx_s3     <= pos_c[bwt_pkg::POS_W-1:PW];
			frac_s3    <= pos_c[PW-1:0];
		end
	end

	// stage 4: neighbor index wraps to zero at the end of the band
	always_comb begin
		idx_c = (idx_s3 >= len_s3) ? (len_s3 - LW'(1)) : idx_s3;
		inc_c = idx_c + LW'(1);
		nxt_c = (inc_c >= len_s3) ? '0 : inc_c;
	end

	// sample loads write at the same stage where queries read
	assign ram_we = valid_s3 && en_s4 && (op_s3 == bwt_pkg::OP_LOAD_SAMPLE) &&
		sidx_ok_s3 && ({1'b0, band_s3} < 5'(NB));

	bwt_ram #(
		.WIDTH (SB),
		.DEPTH (bwt_pkg::DEPTH)
	) u_sample_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   ({band_s3, sidx_s3}),
		.wdata   (value_s3),
		.re      (en_s4),
		.raddr_a ({sel_s3, idx_c[SW-1:0]}),
		.raddr_b ({sel_s3, nxt_c[SW-1:0]}),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	assign ctl_c.silent = silent_s3;
	assign ctl_c.band   = sel_s3;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ctl_s4  <= ctl_c;
			frac_s4 <= frac_s3;
		end
	end

	// stages 5 and output: multiply, then floor-shift and add
	bwt_lerp u_lerp (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (valid_s4),
		.up_take   (take_s5),
		.up_ctl    (ctl_s4),
		.samp_a    ($signed(ram_a)),
		.samp_b    ($signed(ram_b)),
		.frac      (frac_s4),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.mul_valid (mul_valid)
	);

	// input backs up only when every stage holds a word and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && mul_valid &&
			res_valid && res_stall))
		else $error("cmd_stall with a bubble in the pipeline");

	// picked band never lies past the searched range
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (sel_s2 <= cnt_m1_s2))
		else $error("band pick outside searched range");

	// picked length is one..capacity
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (len_s2 != '0 && len_s2 <= LW'(bwt_pkg::MAX_BAND_SAMPLES)))
		else $error("band length out of range");

	// a silent result carries zero sample and band zero
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.silent) |-> (res.sample_out == '0 && res.band_used == '0))
		else $error("silent result not zeroed");

	// a sample load that writes the RAM never enters the result path
	a_ram_order: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> !(valid_s4 && $past(op_s3 == bwt_pkg::OP_LOAD_SAMPLE) && $past(en_s4)))
		else $error("sample load reached the result path");

endmodule

/* test/band_limited_wavetable_lookup_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for band_limited_wavetable_lookup: directed corners, then
// random load/query traffic under several idle and stall mixes. Depends on bwt_pkg and the DUT.
module band_limited_wavetable_lookup_tb;

	// Leave margin for loads still in the pipe.
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 500000;

	logic                      clk;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_stall;
	bwt_pkg::cmd_word_t        cmd;
	logic                      res_valid;
	logic                      res_stall;
	bwt_pkg::res_word_t        res;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [0:0]                cfg_index;
	logic [bwt_pkg::CFG_W-1:0] cfg_data;

	band_limited_wavetable_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block: descriptors, sample memory and registers.
	// tbl_written marks sample entries loaded since reset; memory is not cleared,
	// so a query must never read an entry that is still clear here.
	logic [bwt_pkg::FREQ_W-1:0] tbl_upper   [bwt_pkg::NUM_BANDS];
	logic [11:0]                tbl_len     [bwt_pkg::NUM_BANDS];
	logic signed [15:0]         tbl_sample  [bwt_pkg::NUM_BANDS][bwt_pkg::MAX_BAND_SAMPLES];
	bit                         tbl_written [bwt_pkg::NUM_BANDS][bwt_pkg::MAX_BAND_SAMPLES];
	logic [bwt_pkg::FREQ_W-1:0] lowest_freq;
	logic [bwt_pkg::TCNT_W-1:0] band_count;

	// Lookups accepted and not yet answered, oldest first.
	bwt_pkg::res_word_t lookup_q[$];

	int                 fail_count;
	int unsigned        cycle_count;
	int                 snd_idle_pct;
	int                 rcv_stall_pct;
	int                 hold_req;
	int                 hold_left;
	bwt_pkg::res_word_t want;

	always #5 clk = ~clk;

	// Hard stop in case the block hangs or loses a word.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off for a long stretch on request so
	// that the pipeline fills up and the command side has to stall.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	// Result checker: every word taken off the result channel must match the
	// oldest pending lookup, field by field.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (lookup_q.size() == 0) begin
				$error("result word with no lookup pending: sample_out %0d silent %0d band_used %0d",
					res.sample_out, res.silent, res.band_used);
				fail_count++;
			end else begin
				want = lookup_q.pop_front();
				if (res.sample_out !== want.sample_out) begin
					$error("sample_out expected %0d got %0d", want.sample_out, res.sample_out);
					fail_count++;
				end
				if (res.silent !== want.silent) begin
					$error("silent expected %0d got %0d", want.silent, res.silent);
					fail_count++;
				end
				if (res.band_used !== want.band_used) begin
					$error("band_used expected %0d got %0d", want.band_used, res.band_used);
					fail_count++;
				end
			end
		end
	end

	// Band search and tap addressing for a non-silent lookup. Clamp the band
	// count to 1..NUM_BANDS, fall back to the last searched band when no bound
	// covers the frequency, and treat a zero length as one sample.
	function automatic void locate_taps(input logic [bwt_pkg::FREQ_W-1:0] f,
			input logic [15:0] ph,
			output int unsigned sel, output int unsigned idx, output int unsigned nxt,
			output int unsigned frac);
		int unsigned cnt;
		int unsigned len;
		int unsigned pos;
		bit          found;
		cnt = band_count;
		if (cnt < 1)
			cnt = 1;
		if (cnt > bwt_pkg::NUM_BANDS)
			cnt = bwt_pkg::NUM_BANDS;
		sel   = cnt - 1;
		found = 0;
		for (int unsigned i = 0; i < cnt; i++) begin
			if (!found && tbl_upper[i] >= f) begin
				sel   = i;
				found = 1;
			end
		end
		len = tbl_len[sel];
		if (len < 1)
			len = 1;
		pos  = ph * len;
		idx  = pos >> 16;
		frac = pos & 32'hFFFF;
		if (idx >= len)
			idx = len - 1;
		nxt = idx + 1;
		if (nxt >= len)
			nxt = 0;
	endfunction

	// Expected result of one lookup: silent below the floor frequency, else
	// linear interpolation with a floor on the fractional product.
	function automatic bwt_pkg::res_word_t predict_lookup(
			input logic [bwt_pkg::FREQ_W-1:0] f, input logic [15:0] ph);
		bwt_pkg::res_word_t r;
		int unsigned        sel, idx, nxt, frac;
		longint             a, b, d;
		r = '0;
		if (f < lowest_freq) begin
			r.silent = 1'b1;
			return r;
		end
		locate_taps(f, ph, sel, idx, nxt, frac);
		a = tbl_sample[sel][idx];
		b = tbl_sample[sel][nxt];
		d = (b - a) * longint'(frac);
		r.sample_out = 16'(a + (d >>> 16));
		r.band_used  = 4'(sel);
		return r;
	endfunction

	// A word with every field random; only the op is fixed.
	function automatic bwt_pkg::cmd_word_t rand_word(input bwt_pkg::op_t op);
		bwt_pkg::cmd_word_t w;
		w.op           = op;
		w.band_select  = 4'($urandom);
		w.sample_index = 11'($urandom);
		w.sample_value = 16'($urandom);
		w.upper_bound  = 24'($urandom);
		w.band_length  = 12'($urandom);
		w.frequency    = 24'($urandom);
		w.phase        = 16'($urandom);
		return w;
	endfunction

	// Offer one word, hold it until accepted, then update the shadow copy in
	// order. Idle the command side afterwards as the current mix asks.
	task automatic push_word(input bwt_pkg::cmd_word_t w);
		cmd       <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		case (w.op)
			bwt_pkg::OP_QUERY:
				lookup_q.push_back(predict_lookup(w.frequency, w.phase));
			bwt_pkg::OP_LOAD_DESC: begin
				tbl_upper[w.band_select] = w.upper_bound;
				tbl_len[w.band_select]   = (w.band_length > bwt_pkg::MAX_BAND_SAMPLES) ?
					12'(bwt_pkg::MAX_BAND_SAMPLES) : w.band_length;
			end
			bwt_pkg::OP_LOAD_SAMPLE: begin
				tbl_sample[w.band_select][w.sample_index]  = w.sample_value;
				tbl_written[w.band_select][w.sample_index] = 1'b1;
			end
			default: ;
		endcase
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic load_band(input int unsigned band,
			input logic [bwt_pkg::FREQ_W-1:0] upper, input logic [11:0] len);
		bwt_pkg::cmd_word_t w;
		w             = rand_word(bwt_pkg::OP_LOAD_DESC);
		w.band_select = 4'(band);
		w.upper_bound = upper;
		w.band_length = len;
		push_word(w);
	endtask

	task automatic load_sample(input int unsigned band, input int unsigned index,
			input logic signed [15:0] value);
		bwt_pkg::cmd_word_t w;
		w              = rand_word(bwt_pkg::OP_LOAD_SAMPLE);
		w.band_select  = 4'(band);
		w.sample_index = 11'(index);
		w.sample_value = value;
		push_word(w);
	endtask

	// Send a lookup; first load any tap it would read that was never written.
	task automatic send_query(input logic [bwt_pkg::FREQ_W-1:0] f, input logic [15:0] ph);
		bwt_pkg::cmd_word_t w;
		int unsigned        sel, idx, nxt, frac;
		if (f >= lowest_freq) begin
			locate_taps(f, ph, sel, idx, nxt, frac);
			if (!tbl_written[sel][idx])
				load_sample(sel, idx, 16'($urandom));
			if (!tbl_written[sel][nxt])
				load_sample(sel, nxt, 16'($urandom));
		end
		w           = rand_word(bwt_pkg::OP_QUERY);
		w.frequency = f;
		w.phase     = ph;
		push_word(w);
	endtask

	// Drop valid, wait for every pending lookup, then let in-flight loads land.
	task automatic wait_quiet();
		cmd_valid <= 1'b0;
		while (lookup_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Register write, only with the pipeline empty.
	task automatic set_register(input bwt_pkg::cfg_reg_t r,
			input logic [bwt_pkg::CFG_W-1:0] value);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (r == bwt_pkg::CFG_LOWEST_FREQ)
			lowest_freq = value;
		else
			band_count = value[bwt_pkg::TCNT_W-1:0];
	endtask

	// Frequencies that sit on band bounds and on the silence floor hit the
	// compare edges far more often than uniform picks would.
	function automatic logic [bwt_pkg::FREQ_W-1:0] pick_freq();
		case ($urandom_range(4))
			0:       return tbl_upper[$urandom_range(bwt_pkg::NUM_BANDS - 1)];
			1:       return tbl_upper[$urandom_range(bwt_pkg::NUM_BANDS - 1)] + 24'd1;
			2:       return lowest_freq - 24'($urandom_range(1));
			default: return 24'($urandom);
		endcase
	endfunction

	// Mostly short bands; now and then a full, zero or oversized length.
	function automatic logic [11:0] pick_len();
		case ($urandom_range(19))
			0:       return 12'(bwt_pkg::MAX_BAND_SAMPLES);
			1:       return 12'd0;
			2:       return 12'($urandom);
			default: return 12'($urandom_range(16, 1));
		endcase
	endfunction

	task automatic random_item();
		int unsigned pick, band, span;
		pick = $urandom_range(99);
		if (pick < 10) begin
			load_band($urandom_range(bwt_pkg::NUM_BANDS - 1), 24'($urandom), pick_len());
		end else if (pick < 40) begin
			band = $urandom_range(bwt_pkg::NUM_BANDS - 1);
			span = (tbl_len[band] == 0) ? 1 : tbl_len[band];
			if ($urandom_range(3) == 0)
				load_sample(band, $urandom_range(bwt_pkg::MAX_BAND_SAMPLES - 1),
					16'($urandom));
			else
				load_sample(band, $urandom_range(span - 1), 16'($urandom));
		end else if (pick < 95) begin
			send_query(pick_freq(), 16'($urandom));
		end else begin
			push_word(rand_word(bwt_pkg::OP_NONE));
		end
	endtask

	// Defaults after reset: one band searched, zero length acting as one sample.
	task automatic test_reset_defaults();
		send_query(24'd0, 16'h0000);
		send_query(24'hFFFFFF, 16'hFFFF);
	endtask

	// Full-scale samples, interpolation endpoints, tap wrap, length saturation
	// and the unused op.
	task automatic test_directed_corners();
		load_band(0, 24'd1000, 12'd2);
		load_sample(0, 0, -16'sd32768);
		load_sample(0, 1, 16'sd32767);
		send_query(24'd500, 16'h0000);
		send_query(24'd500, 16'h7FFF);
		send_query(24'd500, 16'h8000);
		send_query(24'd500, 16'hFFFF);
		load_band(1, 24'hFFFFFF, 12'd4095);
		load_sample(1, bwt_pkg::MAX_BAND_SAMPLES - 1, 16'sd32767);
		load_sample(1, 0, -16'sd32768);
		load_band(15, 24'd0, 12'd0);
		push_word(rand_word(bwt_pkg::OP_NONE));
	endtask

	// Band count clamps at both ends, exact bound match, fallback to the last
	// band, and the silence floor at full scale.
	task automatic test_config_extremes();
		set_register(bwt_pkg::CFG_TABLE_COUNT, 24'd31);
		send_query(24'hFFFFFF, 16'hFFFF);
		send_query(24'd1001, 16'h1234);
		send_query(24'd1000, 16'hC000);
		load_band(1, 24'd5000, 12'(bwt_pkg::MAX_BAND_SAMPLES));
		set_register(bwt_pkg::CFG_TABLE_COUNT, 24'd16);
		send_query(24'hFFFFFF, 16'h4000);
		set_register(bwt_pkg::CFG_TABLE_COUNT, 24'd0);
		send_query(24'hFFFFFF, 16'h8000);
		set_register(bwt_pkg::CFG_LOWEST_FREQ, 24'hFFFFFF);
		send_query(24'hFFFFFE, 16'h8000);
		send_query(24'hFFFFFF, 16'h8000);
		set_register(bwt_pkg::CFG_LOWEST_FREQ, 24'd0);
	endtask

	// Random traffic under one idle/stall mix, with fresh register values.
	task automatic test_random_traffic(input int items, input int snd_pct, input int rcv_pct);
		set_register(bwt_pkg::CFG_LOWEST_FREQ,
			($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(24'h3FFFFF)));
		set_register(bwt_pkg::CFG_TABLE_COUNT, 24'($urandom));
		snd_idle_pct  = snd_pct;
		rcv_stall_pct = rcv_pct;
		repeat (items)
			random_item();
	endtask

	// Hold the result side off while lookups keep coming so the pipeline fills.
	task automatic test_backpressure();
		wait_quiet();
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_req      = 150;
		repeat (60)
			send_query(pick_freq(), 16'($urandom));
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		cmd           = '0;
		res_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		fail_count    = 0;
		cycle_count   = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_req      = 0;
		hold_left     = 0;
		lowest_freq   = '0;
		band_count    = 5'd1;
		for (int i = 0; i < bwt_pkg::NUM_BANDS; i++) begin
			tbl_upper[i] = '0;
			tbl_len[i]   = '0;
		end

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_corners();
		test_config_extremes();
		test_random_traffic(400, 0, 0);
		test_random_traffic(400, 75, 0);
		test_backpressure();
		test_random_traffic(400, 0, 75);
		test_random_traffic(400, 23, 23);
		wait_quiet();

		if (fail_count == 0 && lookup_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
sv/bwt_pkg.sv
sv/bwt_ram.sv
sv/bwt_band_table.sv
sv/bwt_lerp.sv
sv/band_limited_wavetable_lookup.sv
test/band_limited_wavetable_lookup_tb.sv
